// File: hdl/fbip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fbip_pkg
// Shared widths, constants and control types for the file block index path.
// ---------------------------------------------------------------------------
package fbip_pkg;

  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned LOG_W    = 2;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned IDX_W    = 10;
  // logical block number width at the smallest block size
  localparam int unsigned BLK_W    = OFFSET_W - 10;
  // limits need one bit above the block number
  localparam int unsigned LIM_W    = BLK_W + 1;

  localparam logic [LOG_W-1:0]   LOG_MAX      = 2'd2;
  localparam logic [LIM_W-1:0]   DIRECT_SLOTS = 23'd12;
  localparam logic [SLOT_W-1:0]  SLOT_BASE    = 4'd11;

  localparam logic [LEVEL_W-1:0] LVL_DIRECT = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_SINGLE = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_DOUBLE = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_TRIPLE = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic calc;
    logic load_out;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/fbip_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fbip_in_if
// Input channel: one byte offset per item.
// ---------------------------------------------------------------------------
interface fbip_in_if;
  logic                           valid;
  logic                           ready;
  logic [fbip_pkg::OFFSET_W-1:0]  byte_offset;

  modport source (output valid, output byte_offset, input ready);
  modport sink   (input valid, input byte_offset, output ready);
endinterface
`default_nettype wire

// File: hdl/fbip_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fbip_out_if
// Result channel: level, inode slot and three pointer indices per item.
// ---------------------------------------------------------------------------
interface fbip_out_if;
  logic                          valid;
  logic                          ready;
  logic [fbip_pkg::LEVEL_W-1:0]  level;
  logic [fbip_pkg::SLOT_W-1:0]   slot;
  logic [fbip_pkg::IDX_W-1:0]    first_index;
  logic [fbip_pkg::IDX_W-1:0]    second_index;
  logic [fbip_pkg::IDX_W-1:0]    third_index;

  modport source (output valid, output level, output slot, output first_index,
                  output second_index, output third_index, input ready);
  modport sink   (input valid, input level, input slot, input first_index,
                  input second_index, input third_index, output ready);
endinterface
`default_nettype wire

// File: hdl/fbip_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fbip_cfg_if
// Configuration write channel for the block size log register.
// ---------------------------------------------------------------------------
interface fbip_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fbip_pkg::LOG_W-1:0]   log_block_size;

  modport source (output valid, output log_block_size, input ready);
  modport sink   (input valid, input log_block_size, output ready);
endinterface
`default_nettype wire

// File: hdl/fbip_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fbip_ctrl
// Sequencer: accept, level select, index split, then output register load.
// ---------------------------------------------------------------------------
module fbip_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fbip_pkg::cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LEVEL = 2'd1;
  localparam logic [1:0] S_SPLIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.calc  = 1'b1;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        // wait until the output register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: hdl/fbip_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fbip_dp
// Datapath: config register, level select with base subtract, index split.
// ---------------------------------------------------------------------------
module fbip_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fbip_pkg::cmd_t                cmd,
  input  wire logic                          cfg_we,
  input  wire logic [fbip_pkg::LOG_W-1:0]    cfg_data,
  input  wire logic [fbip_pkg::OFFSET_W-1:0] byte_offset,
  output logic [fbip_pkg::LEVEL_W-1:0]       level,
  output logic [fbip_pkg::SLOT_W-1:0]        slot,
  output logic [fbip_pkg::IDX_W-1:0]         first_index,
  output logic [fbip_pkg::IDX_W-1:0]         second_index,
  output logic [fbip_pkg::IDX_W-1:0]         third_index
);

  logic [fbip_pkg::LOG_W-1:0]    log_r;
  logic [fbip_pkg::OFFSET_W-1:0] offset_r;
  logic [fbip_pkg::LEVEL_W-1:0]  lvl_r, lvl_nxt;
  logic [fbip_pkg::BLK_W-1:0]    rem_r, rem_nxt;

  logic [fbip_pkg::LEVEL_W-1:0]  level_r;
  logic [fbip_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [fbip_pkg::IDX_W-1:0]    idx1_r, idx1_nxt;
  logic [fbip_pkg::IDX_W-1:0]    idx2_r, idx2_nxt;
  logic [fbip_pkg::IDX_W-1:0]    idx3_r, idx3_nxt;

  logic [fbip_pkg::LOG_W-1:0]    lg;
  logic [3:0]                    psh;
  logic [fbip_pkg::BLK_W-1:0]    blk;
  logic [fbip_pkg::LIM_W-1:0]    blk_x, lim1, lim2;
  logic [fbip_pkg::BLK_W-1:0]    mask;
  logic [fbip_pkg::IDX_W-1:0]    lo, mid, hi;

  // out-of-range log saturates to the largest block size
  assign lg  = (log_r > fbip_pkg::LOG_MAX) ? fbip_pkg::LOG_MAX : log_r;
  assign psh = 4'd8 + {2'b00, lg};

  // level select and base subtract
  always_comb begin
    blk   = fbip_pkg::BLK_W'(offset_r >> (5'd10 + {3'b000, lg}));
    blk_x = {1'b0, blk};
    lim1  = fbip_pkg::DIRECT_SLOTS + (fbip_pkg::LIM_W'(1) << psh);
    lim2  = lim1 + (fbip_pkg::LIM_W'(1) << {psh, 1'b0});
    if (blk_x < fbip_pkg::DIRECT_SLOTS) begin
      lvl_nxt = fbip_pkg::LVL_DIRECT;
      rem_nxt = blk;
    end else if (blk_x < lim1) begin
      lvl_nxt = fbip_pkg::LVL_SINGLE;
      rem_nxt = fbip_pkg::BLK_W'(blk_x - fbip_pkg::DIRECT_SLOTS);
    end else if (blk_x < lim2) begin
      lvl_nxt = fbip_pkg::LVL_DOUBLE;
      rem_nxt = fbip_pkg::BLK_W'(blk_x - lim1);
    end else begin
      lvl_nxt = fbip_pkg::LVL_TRIPLE;
      rem_nxt = fbip_pkg::BLK_W'(blk_x - lim2);
    end
  end

  // index split, least significant index belongs to the deepest level
  always_comb begin
    mask = (fbip_pkg::BLK_W'(1) << psh) - fbip_pkg::BLK_W'(1);
    lo   = fbip_pkg::IDX_W'(rem_r & mask);
    mid  = fbip_pkg::IDX_W'((rem_r >> psh) & mask);
    hi   = fbip_pkg::IDX_W'((rem_r >> {psh, 1'b0}) & mask);
    idx1_nxt = '0;
    idx2_nxt = '0;
    idx3_nxt = '0;
    slot_nxt = fbip_pkg::SLOT_BASE + {2'b00, lvl_r};
    case (lvl_r)
      fbip_pkg::LVL_DIRECT: begin
        slot_nxt = rem_r[fbip_pkg::SLOT_W-1:0];
      end
      fbip_pkg::LVL_SINGLE: begin
        idx1_nxt = lo;
      end
      fbip_pkg::LVL_DOUBLE: begin
        idx1_nxt = mid;
        idx2_nxt = lo;
      end
      fbip_pkg::LVL_TRIPLE: begin
        idx1_nxt = hi;
        idx2_nxt = mid;
        idx3_nxt = lo;
      end
      default: begin
        slot_nxt = rem_r[fbip_pkg::SLOT_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_r <= '0;
    end else if (cfg_we) begin
      log_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      offset_r <= byte_offset;
    end
    if (cmd.calc) begin
      lvl_r <= lvl_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      level_r <= lvl_r;
      slot_r  <= slot_nxt;
      idx1_r  <= idx1_nxt;
      idx2_r  <= idx2_nxt;
      idx3_r  <= idx3_nxt;
    end
  end

  assign level        = level_r;
  assign slot         = slot_r;
  assign first_index  = idx1_r;
  assign second_index = idx2_r;
  assign third_index  = idx3_r;

endmodule
`default_nettype wire

// File: hdl/file_block_index_path_top.sv
`timescale 1ns / 1ps
`default_nettype none
// result path: the accepted offset is registered, then the level and remainder, then the output register
// flow: the sequencer (accept, level select, index split) handles one offset at
//   a time and holds in index split while the output register holds an untaken result
// a finished result waits in the output register while the next item is taken
// reset: synchronous active-low rst_n clears the sequencer, output valid and
//   the block size log (1024-byte blocks)
// ---------------------------------------------------------------------------
// file_block_index_path_top
// Maps a file byte offset onto the inode block-map path: level, slot and
// up to three indirect pointer indices.
// ---------------------------------------------------------------------------
module file_block_index_path_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fbip_in_if.sink     in_ch,
  fbip_out_if.source  out_ch,
  fbip_cfg_if.sink    cfg_ch
);

  fbip_pkg::cmd_t cmd;

  // config register is always writable; writes must come only while idle, which the block does not enforce
  assign cfg_ch.ready = 1'b1;

  // sequencer: owns the input ready and the result valid flag
  fbip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: offset capture, level select, index split, output register
  fbip_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_ch.valid),
    .cfg_data     (cfg_ch.log_block_size),
    .byte_offset  (in_ch.byte_offset),
    .level        (out_ch.level),
    .slot         (out_ch.slot),
    .first_index  (out_ch.first_index),
    .second_index (out_ch.second_index),
    .third_index  (out_ch.third_index)
  );

endmodule
`default_nettype wire

// File: hdl/fbip_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fbip_chk
// Port-level checks on the file block index path, bound to the top level.
// ---------------------------------------------------------------------------
module fbip_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [fbip_pkg::LEVEL_W-1:0]  level,
  input wire logic [fbip_pkg::SLOT_W-1:0]   slot,
  input wire logic [fbip_pkg::IDX_W-1:0]    first_index,
  input wire logic [fbip_pkg::IDX_W-1:0]    second_index,
  input wire logic [fbip_pkg::IDX_W-1:0]    third_index
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  // one item in flight: no new item right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // with the output free at accept, the result follows after level select and index split
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  // direct blocks use no pointer indices and a direct slot
  a_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && level == fbip_pkg::LVL_DIRECT) |->
      (first_index == '0 && second_index == '0 && third_index == '0 &&
       slot < fbip_pkg::SLOT_W'(12)))
    else $error("direct result carries pointer indices");

  // single indirect uses slot twelve and one index only
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && level == fbip_pkg::LVL_SINGLE) |->
      (second_index == '0 && third_index == '0 && slot == fbip_pkg::SLOT_W'(12)))
    else $error("single indirect result malformed");

endmodule

bind file_block_index_path_top fbip_chk u_fbip_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .level        (out_ch.level),
  .slot         (out_ch.slot),
  .first_index  (out_ch.first_index),
  .second_index (out_ch.second_index),
  .third_index  (out_ch.third_index)
);
`default_nettype wire

// File: tb/sv/file_block_index_path_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// file_block_index_path_top_tb
// Self-checking bench for the offset to block-map path lookup. Byte offsets
// go in under random gaps and output stalls, every result is checked field
// by field against a local mapping model, and the block size log is swept
// over all register values between phases.
// ---------------------------------------------------------------------------
module file_block_index_path_top_tb;

  // one result item as the block presents it
  typedef struct packed {
    logic [fbip_pkg::LEVEL_W-1:0] level;
    logic [fbip_pkg::SLOT_W-1:0]  slot;
    logic [fbip_pkg::IDX_W-1:0]   first_index;
    logic [fbip_pkg::IDX_W-1:0]   second_index;
    logic [fbip_pkg::IDX_W-1:0]   third_index;
  } block_path_t;

  localparam int LONG_HOLD   = 300;        // cycles of output stall in the pressure test
  localparam int PHASE_ITEMS = 200;        // random items per register setting
  localparam int TAIL_CYCLES = 8;          // extra wait after the drain

  logic clk = 1'b0;
  logic rst_n;

  fbip_in_if  in_ch ();
  fbip_out_if out_ch ();
  fbip_cfg_if cfg_ch ();

  file_block_index_path_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  block_path_t                expected_paths[$];  // mappings waiting for their result item
  logic [fbip_pkg::LOG_W-1:0] log_size_cfg;       // local copy of the block size log
  int                         mismatch_count = 0;
  bit                         no_gaps = 1'b0;     // stretch with no idling on either side
  bit                         hold_req = 1'b0;    // ask the sink for one long stall
  bit                         holding = 1'b0;     // sink is inside that stall

  // ---------------------------------------------------------------------------
  // mapping model
  // ---------------------------------------------------------------------------

  // first logical block of a level; level 4 is the end of triple indirect
  function automatic logic [63:0] level_start(input int lvl,
                                              input logic [fbip_pkg::LOG_W-1:0] log_sz);
    logic [fbip_pkg::LOG_W-1:0] lg;
    int                         psh;
    logic [63:0]                start;
    lg    = (log_sz > fbip_pkg::LOG_MAX) ? fbip_pkg::LOG_MAX : log_sz;
    psh   = 8 + lg;
    start = 64'd0;
    if (lvl >= 1) start = 64'(fbip_pkg::DIRECT_SLOTS);
    if (lvl >= 2) start = start + (64'd1 << psh);
    if (lvl >= 3) start = start + (64'd1 << (2 * psh));
    if (lvl >= 4) start = start + (64'd1 << (3 * psh));
    return start;
  endfunction

  function automatic block_path_t map_offset(input logic [fbip_pkg::OFFSET_W-1:0] offset,
                                             input logic [fbip_pkg::LOG_W-1:0] log_sz);
    logic [fbip_pkg::LOG_W-1:0] lg;
    int                         psh;
    int                         d;
    logic [31:0]                blk;
    logic [63:0]                pmask;
    logic [63:0]                rem;
    logic [fbip_pkg::IDX_W-1:0] idx [1:3];
    block_path_t                path;
    lg    = (log_sz > fbip_pkg::LOG_MAX) ? fbip_pkg::LOG_MAX : log_sz;  // value 3 saturates
    psh   = 8 + lg;                                   // log2 of pointers per block
    pmask = (64'd1 << psh) - 64'd1;
    blk   = offset >> (10 + lg);
    idx[1] = '0;
    idx[2] = '0;
    idx[3] = '0;
    if (blk < level_start(1, lg)) begin
      path.level = fbip_pkg::LVL_DIRECT;
      rem = 64'(blk);
    end else if (blk < level_start(2, lg)) begin
      path.level = fbip_pkg::LVL_SINGLE;
      rem = blk - level_start(1, lg);
    end else if (blk < level_start(3, lg)) begin
      path.level = fbip_pkg::LVL_DOUBLE;
      rem = blk - level_start(2, lg);
    end else begin
      path.level = fbip_pkg::LVL_TRIPLE;
      rem = blk - level_start(3, lg);
    end
    // deepest index takes the low bits, most significant ends up first
    for (d = path.level; d > 0; d--) begin
      idx[d] = fbip_pkg::IDX_W'(rem & pmask);
      rem    = rem >> psh;
    end
    path.slot         = (path.level == fbip_pkg::LVL_DIRECT) ?
                        blk[fbip_pkg::SLOT_W-1:0] : fbip_pkg::SLOT_BASE + path.level;
    path.first_index  = idx[1];
    path.second_index = idx[2];
    path.third_index  = idx[3];
    return path;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // offsets aimed at every reachable level, near its edges part of the time
  function automatic logic [fbip_pkg::OFFSET_W-1:0] pick_offset(
      input logic [fbip_pkg::LOG_W-1:0] log_sz);
    logic [fbip_pkg::LOG_W-1:0] lg;
    int                         shift;
    int                         lvl;
    int                         r;
    logic [63:0]                max_blk;
    logic [63:0]                lo;
    logic [63:0]                hi;
    logic [63:0]                blk;
    lg      = (log_sz > fbip_pkg::LOG_MAX) ? fbip_pkg::LOG_MAX : log_sz;
    shift   = 10 + lg;
    max_blk = 64'hFFFF_FFFF >> shift;
    r       = $urandom_range(0, 99);
    lvl     = $urandom_range(0, 3);
    lo      = level_start(lvl, lg);
    hi      = level_start(lvl + 1, lg) - 64'd1;
    if (hi > max_blk) hi = max_blk;
    // plain random offsets, and any level the offset width cannot reach
    if (r < 20 || lo > max_blk) return $urandom();
    if (r < 35) begin
      blk = $urandom_range(0, 1) ? lo + $urandom_range(0, 2) : hi - $urandom_range(0, 2);
      if (blk < lo) blk = lo;
      if (blk > hi) blk = hi;
    end else begin
      blk = lo + ({$urandom(), $urandom()} % (hi - lo + 64'd1));
    end
    return fbip_pkg::OFFSET_W'(blk << shift) | ($urandom() & ((32'd1 << shift) - 32'd1));
  endfunction

  // one offset item; valid stays up when the next item follows at once
  task automatic send_offset(input logic [fbip_pkg::OFFSET_W-1:0] offset);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.byte_offset <= offset;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_paths.push_back(map_offset(offset, log_size_cfg));
    gap = idle_cycles();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result item
  task automatic wait_paths_drained();
    in_ch.valid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
  endtask

  // register writes only with the block empty
  task automatic write_log_size(input logic [fbip_pkg::LOG_W-1:0] value);
    wait_paths_drained();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.log_block_size <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    log_size_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value of the register with the extremes of the offset
  task automatic test_reset_setting();
    send_offset(32'h0000_0000);
    send_offset(32'hFFFF_FFFF);
    send_offset(32'hAAAA_AAAA);
    send_offset(32'h5555_5555);
  endtask

  // last and first block around each level change, where reachable
  task automatic test_level_boundaries(input logic [fbip_pkg::LOG_W-1:0] log_sz);
    logic [63:0] edge_blk;
    int          shift;
    int          lvl;
    shift = 10 + ((log_sz > fbip_pkg::LOG_MAX) ? fbip_pkg::LOG_MAX : log_sz);
    write_log_size(log_sz);
    for (lvl = 1; lvl <= 3; lvl++) begin
      edge_blk = level_start(lvl, log_sz);
      if ((edge_blk << shift) - 64'd1 <= 64'hFFFF_FFFF)
        send_offset(fbip_pkg::OFFSET_W'((edge_blk << shift) - 64'd1));
      if ((edge_blk << shift) <= 64'hFFFF_FFFF)
        send_offset(fbip_pkg::OFFSET_W'(edge_blk << shift));
    end
  endtask

  // out-of-range register value saturates to 4096-byte blocks
  task automatic test_log_saturation();
    write_log_size(2'd3);
    send_offset(fbip_pkg::OFFSET_W'(level_start(2, 2'd3) << 12));
    send_offset(fbip_pkg::OFFSET_W'((level_start(2, 2'd3) << 12) - 64'd1));
    send_offset(32'hFFFF_FFFF);
  endtask

  // sink holds off long while items keep coming, so the block fills and stalls
  task automatic test_output_stall();
    int n;
    hold_req = 1'b1;
    wait (holding);
    no_gaps = 1'b1;
    for (n = 0; n < 40; n++) send_offset(pick_offset(log_size_cfg));
    no_gaps = 1'b0;
  endtask

  // random offsets under each register setting, with and without idling
  task automatic test_random_offsets();
    logic [fbip_pkg::LOG_W-1:0] phase_log [7];
    int                         p;
    int                         n;
    phase_log = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd2,
                  fbip_pkg::LOG_W'($urandom_range(0, 3))};
    for (p = 0; p < 7; p++) begin
      write_log_size(phase_log[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_offset(pick_offset(log_size_cfg));
      end
      no_gaps = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
    end
  endtask

  // sampled at the edge, before any of this edge's updates land
  always @(posedge clk) begin
    block_path_t exp_path;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_paths.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result item with none expected, actual level %0d slot %0d",
                 $time, out_ch.level, out_ch.slot);
      end else begin
        exp_path = expected_paths.pop_front();
        check_field("level", exp_path.level, out_ch.level);
        check_field("slot", exp_path.slot, out_ch.slot);
        check_field("first_index", exp_path.first_index, out_ch.first_index);
        check_field("second_index", exp_path.second_index, out_ch.second_index);
        check_field("third_index", exp_path.third_index, out_ch.third_index);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random ready with stretches of stall, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_ch.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        holding = 1'b0;
      end else if (no_gaps || $urandom_range(0, 99) >= 30) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (1 + idle_cycles()) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.byte_offset     <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.log_block_size <= '0;
    log_size_cfg = '0;                     // register reset value
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_level_boundaries(2'd0);
    test_level_boundaries(2'd1);
    test_level_boundaries(2'd2);
    test_log_saturation();
    test_output_stall();
    test_random_offsets();

    // drain, then wait TAIL_CYCLES to catch any stray result item
    wait_paths_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
